FILE: sv/rkd_pkg.sv
// Shared types, constants and lookup functions for the remote key decoder.
// Depends on nothing; every other file of the block imports it.
package rkd_pkg;

   localparam int KEY_COUNT     = 21;
   localparam int COLUMN_COUNT  = 8;
   localparam int DIGIT_COUNT   = 10;
   localparam int VALUE_WIDTH   = 27;
   localparam int KEY_WIDTH     = 5;
   localparam int COLUMN_WIDTH  = 3;
   localparam int TIMEOUT_WIDTH = 16;
   localparam int WORD_WIDTH    = 32;

   localparam logic [KEY_WIDTH-1:0]     KEY_LAST_DIGIT = 5'd9;
   localparam logic [KEY_WIDTH-1:0]     KEY_EXIT       = 5'd10;
   localparam logic [COLUMN_WIDTH-1:0]  COLUMN_LAST    = 3'd7;
   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET  = 16'd1500;
   localparam logic [TIMEOUT_WIDTH-1:0] IDLE_MAX       = 16'hFFFF;

   typedef enum logic [1:0] {
      EVT_KEY     = 2'd0,
      EVT_COLUMN  = 2'd1,
      EVT_FINISH  = 2'd2,
      EVT_UNKNOWN = 2'd3
   } event_kind_type;

   typedef struct packed {
      event_kind_type         kind;
      logic [KEY_WIDTH-1:0]   key;
      logic [VALUE_WIDTH-1:0] number;
      logic                   multi;
   } job_type;

   typedef struct packed {
      logic                 found;
      logic [KEY_WIDTH-1:0] key;
   } key_match_type;

   localparam logic [WORD_WIDTH-1:0] KEY_CODES [KEY_COUNT][2] = '{
      '{32'd11184811, 32'd19573419}, '{32'd11184813, 32'd19573421},
      '{32'd11184819, 32'd19573427}, '{32'd11184821, 32'd19573429},
      '{32'd11184843, 32'd19573451}, '{32'd11184845, 32'd19573453},
      '{32'd11184851, 32'd19573459}, '{32'd11184853, 32'd19573461},
      '{32'd11184939, 32'd19573547}, '{32'd11184941, 32'd19573549},
      '{32'd11184981, 32'd19573589}, '{32'd11186859, 32'd19575467},
      '{32'd11184971, 32'd19573579}, '{32'd11185325, 32'd19573933},
      '{32'd11187027, 32'd19575635}, '{32'd11185323, 32'd19573931},
      '{32'd11184973, 32'd19573581}, '{32'd11186861, 32'd19575469},
      '{32'd11186867, 32'd19575475}, '{32'd11185491, 32'd19574099},
      '{32'd11186899, 32'd19575507}
   };

   localparam logic [7:0] GLYPHS [DIGIT_COUNT][COLUMN_COUNT] = '{
      '{8'h00, 8'h00, 8'h7F, 8'h41, 8'h41, 8'h41, 8'h7F, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h7F, 8'h02, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h4F, 8'h49, 8'h49, 8'h49, 8'h79, 8'h00},
      '{8'h00, 8'h00, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h41, 8'h00},
      '{8'h00, 8'h00, 8'h7F, 8'h08, 8'h08, 8'h08, 8'h0F, 8'h00},
      '{8'h00, 8'h00, 8'h79, 8'h49, 8'h49, 8'h49, 8'h4F, 8'h00},
      '{8'h00, 8'h00, 8'h79, 8'h49, 8'h49, 8'h49, 8'h7F, 8'h00},
      '{8'h00, 8'h00, 8'h07, 8'h09, 8'h71, 8'h01, 8'h01, 8'h00},
      '{8'h00, 8'h00, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h7F, 8'h00},
      '{8'h00, 8'h00, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h4F, 8'h00}
   };

   // largest entry: 10^digits - 1, clamped to the value width
   function automatic logic [VALUE_WIDTH-1:0] entry_limit(input int digits);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < digits; i++) begin
         p = p * 64'd10;
      end
      p = p - 64'd1;
      if (p > {{(64-VALUE_WIDTH){1'b0}}, {VALUE_WIDTH{1'b1}}}) begin
         p = {{(64-VALUE_WIDTH){1'b0}}, {VALUE_WIDTH{1'b1}}};
      end
      return p[VALUE_WIDTH-1:0];
   endfunction

   function automatic key_match_type match_key(input logic [WORD_WIDTH-1:0] word);
      key_match_type m;
      m = '0;
      for (int k = KEY_COUNT - 1; k >= 0; k--) begin
         if (KEY_CODES[k][0] == word || KEY_CODES[k][1] == word) begin
            m.found = 1'b1;
            m.key   = KEY_WIDTH'(k);
         end
      end
      return m;
   endfunction

   function automatic logic [7:0] glyph_column(input logic [3:0] digit,
                                               input logic [COLUMN_WIDTH-1:0] column);
      logic [7:0] bits;
      bits = 8'h00;
      if (digit <= 4'd9) begin
         bits = GLYPHS[digit][column];
      end
      return bits;
   endfunction

endpackage

FILE: sv/rkd_front.sv
// Front end: accepts words and ticks, filters repeats, decodes keys and
// keeps the digit entry and idle count. Uses rkd_pkg.
module rkd_front #(
   parameter int ENTRY_DIGITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic                                 opcode,
   input  logic [rkd_pkg::WORD_WIDTH-1:0]       command_word,
   input  logic                                 csr_write_enable,
   input  logic [rkd_pkg::TIMEOUT_WIDTH-1:0]    csr_write_data,
   output logic                                 job_push,
   output rkd_pkg::job_type                     job
);
   import rkd_pkg::*;

   localparam logic [VALUE_WIDTH-1:0] ENTRY_LIMIT = entry_limit(ENTRY_DIGITS);

   logic [TIMEOUT_WIDTH-1:0] timeout_ff, timeout_in;
   logic [WORD_WIDTH-1:0]    previous_ff, previous_in;
   logic [VALUE_WIDTH-1:0]   entry_ff, entry_in;
   logic                     pending_ff, pending_in;
   logic [TIMEOUT_WIDTH-1:0] idle_ff, idle_in;

   logic [TIMEOUT_WIDTH:0]   elapsed;
   logic [VALUE_WIDTH+3:0]   appended;
   key_match_type            match;
   logic                     is_digit;

   always_comb begin
      elapsed  = {1'b0, idle_ff} + {{TIMEOUT_WIDTH{1'b0}}, 1'b1};
      match    = match_key(command_word);
      is_digit = match.key <= KEY_LAST_DIGIT;
      appended = {1'b0, entry_ff, 3'b000} + {3'b000, entry_ff, 1'b0}
               + {{(VALUE_WIDTH-1){1'b0}}, match.key};
   end

   always_comb begin
      timeout_in  = csr_write_enable ? csr_write_data : timeout_ff;
      previous_in = previous_ff;
      entry_in    = entry_ff;
      pending_in  = pending_ff;
      idle_in     = idle_ff;
      job_push    = 1'b0;
      job         = '0;
      if (accept) begin
         if (opcode) begin
            idle_in = elapsed[TIMEOUT_WIDTH] ? IDLE_MAX : elapsed[TIMEOUT_WIDTH-1:0];
            if (pending_ff && elapsed > {1'b0, timeout_ff}) begin
               job_push   = 1'b1;
               job.kind   = EVT_FINISH;
               job.number = entry_ff;
               entry_in   = '0;
               pending_in = 1'b0;
            end
         end else if (command_word != previous_ff) begin
            previous_in = command_word;
            job_push    = 1'b1;
            if (!match.found) begin
               job.kind = EVT_UNKNOWN;
            end else if (is_digit) begin
               job.kind   = EVT_COLUMN;
               job.key    = match.key;
               job.multi  = 1'b1;
               entry_in   = (appended > {4'b0000, ENTRY_LIMIT}) ? ENTRY_LIMIT
                                                              : appended[VALUE_WIDTH-1:0];
               pending_in = 1'b1;
               idle_in    = '0;
            end else if (match.key == KEY_EXIT) begin
               job.kind  = EVT_COLUMN;
               job.key   = KEY_EXIT;
               job.multi = 1'b1;
            end else begin
               job.kind = EVT_KEY;
               job.key  = match.key;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= TIMEOUT_RESET;
         previous_ff <= '0;
         entry_ff    <= '0;
         pending_ff  <= 1'b0;
         idle_ff     <= '0;
      end else begin
         timeout_ff  <= timeout_in;
         previous_ff <= previous_in;
         entry_ff    <= entry_in;
         pending_ff  <= pending_in;
         idle_ff     <= idle_in;
      end
   end

endmodule

FILE: sv/rkd_queue.sv
// Short job queue between the front end and the result sequencer.
// Uses rkd_pkg for the job word.
module rkd_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rkd_pkg::job_type push_job,
   input  logic             pop,
   output rkd_pkg::job_type head_job,
   output logic             full,
   output logic             empty
);
   import rkd_pkg::*;

   localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0]   PTR_LAST   = PTR_WIDTH'(DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = COUNT_WIDTH'(DEPTH);

   job_type                slots_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   always_comb begin
      full     = count_ff == COUNT_FULL;
      empty    = count_ff == '0;
      do_push  = push && !full;
      do_pop   = pop && !empty;
      head_job = slots_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: sv/rkd_back.sv
// Result sequencer: expands each job into result words, one column per
// cycle for display jobs while the output is not stalled, into an output register. Uses rkd_pkg.
module rkd_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 job_ready,
   input  rkd_pkg::job_type                     job,
   output logic                                 job_pop,
   input  logic                                 pop,
   output logic                                 empty,
   output logic [1:0]                           event_kind,
   output logic [rkd_pkg::KEY_WIDTH-1:0]        key_number,
   output logic [rkd_pkg::COLUMN_WIDTH-1:0]     column_index,
   output logic [7:0]                           column_bits,
   output logic                                 relays_off,
   output logic [rkd_pkg::VALUE_WIDTH-1:0]      finished_number,
   output logic                                 last_of_run
);
   import rkd_pkg::*;

   logic                     valid_ff, valid_in;
   logic [COLUMN_WIDTH-1:0]  col_ff, col_in;
   logic                     load;
   logic                     is_exit;
   logic                     job_done;

   logic [1:0]               kind_ff, kind_in;
   logic [KEY_WIDTH-1:0]     key_ff, key_in;
   logic [COLUMN_WIDTH-1:0]  index_ff, index_in;
   logic [7:0]               bits_ff, bits_in;
   logic                     relays_ff, relays_in;
   logic [VALUE_WIDTH-1:0]   number_ff, number_in;
   logic                     last_ff, last_in;

   always_comb begin
      load     = job_ready && (!valid_ff || pop);
      is_exit  = job.key == KEY_EXIT;
      job_done = !job.multi || col_ff == COLUMN_LAST;
      job_pop  = load && job_done;
      valid_in = load || (valid_ff && !pop);
      col_in   = col_ff;
      if (load) begin
         col_in = job_done ? '0 : col_ff + 1'b1;
      end
      kind_in   = job.kind;
      key_in    = job.key;
      number_in = job.number;
      index_in  = job.multi ? col_ff : '0;
      bits_in   = (job.multi && !is_exit) ? glyph_column(job.key[3:0], col_ff) : 8'h00;
      relays_in = job.multi && is_exit;
      last_in   = job_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         col_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         col_ff   <= col_in;
      end
   end

   // hold the payload until the next load
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= kind_in;
         key_ff    <= key_in;
         index_ff  <= index_in;
         bits_ff   <= bits_in;
         relays_ff <= relays_in;
         number_ff <= number_in;
         last_ff   <= last_in;
      end
   end

   assign empty           = !valid_ff;
   assign event_kind      = kind_ff;
   assign key_number      = key_ff;
   assign column_index    = index_ff;
   assign column_bits     = bits_ff;
   assign relays_off      = relays_ff;
   assign finished_number = number_ff;
   assign last_of_run     = last_ff;

endmodule

FILE: sv/remote_key_decoder_digit_entry.sv
// Top level of the remote key decoder with decimal digit entry.
// Instantiates rkd_front, rkd_queue and rkd_back; uses rkd_pkg.
//
//   channel  | ports                              | transfer
//   ---------+------------------------------------+---------------------
//   request  | push, full, req_opcode, req_...    | push && !full
//   response | empty, pop, rsp_...                | pop && !empty
//   csr      | csr_write_enable, csr_write_data   | csr_write_enable
//
// A request word is taken in any cycle the job queue (QUEUE_DEPTH deep) has room.
// Digit and exit keys give 8 result words; every other result is
// one word, set by the column sequencer in rkd_back.
// A request's first result passes the job queue, then the rkd_back output register.
// Reset clears the entry state and loads the timeout with 1500 ticks.
// A stalled response stops the sequencer; the queue then fills and raises full.
module remote_key_decoder_digit_entry #(
   parameter int ENTRY_DIGITS = 8,
   parameter int QUEUE_DEPTH  = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic                                 req_opcode,
   input  logic [rkd_pkg::WORD_WIDTH-1:0]       req_command_word,
   output logic                                 empty,
   input  logic                                 pop,
   output logic [1:0]                           rsp_event_kind,
   output logic [rkd_pkg::KEY_WIDTH-1:0]        rsp_key_number,
   output logic [rkd_pkg::COLUMN_WIDTH-1:0]     rsp_column_index,
   output logic [7:0]                           rsp_column_bits,
   output logic                                 rsp_relays_off,
   output logic [rkd_pkg::VALUE_WIDTH-1:0]      rsp_finished_number,
   output logic                                 rsp_last_of_run,
   input  logic                                 csr_write_enable,
   input  logic [rkd_pkg::TIMEOUT_WIDTH-1:0]    csr_write_data
);
   import rkd_pkg::*;

   logic    accept;
   logic    job_push;
   job_type push_job;
   job_type head_job;
   logic    job_pop;
   logic    queue_empty;

   assign accept = push && !full;

   rkd_front #(
      .ENTRY_DIGITS(ENTRY_DIGITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .opcode           (req_opcode),
      .command_word     (req_command_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .job_push         (job_push),
      .job              (push_job)
   );

   rkd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .full     (full),
      .empty    (queue_empty)
   );

   rkd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_ready       (!queue_empty),
      .job             (head_job),
      .job_pop         (job_pop),
      .pop             (pop),
      .empty           (empty),
      .event_kind      (rsp_event_kind),
      .key_number      (rsp_key_number),
      .column_index    (rsp_column_index),
      .column_bits     (rsp_column_bits),
      .relays_off      (rsp_relays_off),
      .finished_number (rsp_finished_number),
      .last_of_run     (rsp_last_of_run)
   );

endmodule

FILE: sv/rkd_checker.sv
// Port-level checks for remote_key_decoder_digit_entry, bound to the top level.
// Uses rkd_pkg for event codes and column limits.
module rkd_port_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 push,
   input logic                                 full,
   input logic                                 req_opcode,
   input logic [rkd_pkg::WORD_WIDTH-1:0]       req_command_word,
   input logic                                 empty,
   input logic                                 pop,
   input logic [1:0]                           rsp_event_kind,
   input logic [rkd_pkg::KEY_WIDTH-1:0]        rsp_key_number,
   input logic [rkd_pkg::COLUMN_WIDTH-1:0]     rsp_column_index,
   input logic [7:0]                           rsp_column_bits,
   input logic                                 rsp_relays_off,
   input logic [rkd_pkg::VALUE_WIDTH-1:0]      rsp_finished_number,
   input logic                                 rsp_last_of_run,
   input logic                                 csr_write_enable,
   input logic [rkd_pkg::TIMEOUT_WIDTH-1:0]    csr_write_data
);
   import rkd_pkg::*;

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> empty)
      else $error("response not empty after reset");

   a_column_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_event_kind == EVT_COLUMN)
         |-> (rsp_last_of_run == (rsp_column_index == COLUMN_LAST)))
      else $error("last flag does not match final column");

   a_single_word: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_event_kind != EVT_COLUMN)
         |-> (rsp_last_of_run && rsp_column_index == '0 && rsp_column_bits == 8'h00
              && !rsp_relays_off))
      else $error("single result word carries column data");

   a_column_advance: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && rsp_event_kind == EVT_COLUMN && !rsp_last_of_run)
         |=> (!empty && rsp_event_kind == EVT_COLUMN
              && rsp_column_index == $past(rsp_column_index) + 1'b1))
      else $error("column run broken");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_event_kind)
                            && $stable(rsp_column_index) && $stable(rsp_finished_number)))
      else $error("stalled response changed");

endmodule

bind remote_key_decoder_digit_entry rkd_port_checker u_checker (.*);
